// ===== hw/rtl/pip_pkg.sv =====
// shared types and constants for the palette index packer
// no dependencies; imported by every module of the block
package pip_pkg;

  localparam int PIX_W                 = 24;
  localparam int CHAN_W                = 8;
  localparam int IDX_BYTE_W            = 8;
  localparam int COUNT_W               = 9;
  localparam int ADDR_W                = 16;
  localparam int WORD_W                = 32;
  localparam int PIXELS_PER_WORD       = 4;
  localparam int MASK_W                = PIXELS_PER_WORD;
  localparam int GROUP_W               = $clog2(PIXELS_PER_WORD);
  localparam int IN_DATA_W             = 24;
  localparam int OUT_DATA_W            = 64;
  localparam int DEFAULT_PALETTE_DEPTH = 256;
  localparam int QDEPTH                = 2;

  typedef logic [PIX_W-1:0] color_t;

  // one resolved pixel from the search engine
  typedef struct packed {
    logic [IDX_BYTE_W-1:0] idx;
    logic                  miss;
    logic [COUNT_W-1:0]    colors;
  } res_t;

endpackage

// ===== hw/rtl/pip_pixel_queue.sv =====
// front end: accepts pixel transactions and buffers colors in a short queue
// depends on pip_pkg
module pip_pixel_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  pip_pkg::color_t push_color,
  output logic            pop_valid,
  input  logic            pop_ready,
  output pip_pkg::color_t pop_color
);
  import pip_pkg::*;

  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QFILL_W = $clog2(QDEPTH + 1);

  color_t              qmem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QFILL_W-1:0]  fill_r, fill_nxt;
  logic                push, pop;

  assign push_ready = (fill_r != QFILL_W'(QDEPTH));
  assign pop_valid  = (fill_r != '0);
  assign pop_color  = qmem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    fill_nxt   = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + QFILL_W'(1);
    end else if (pop && !push) begin
      fill_nxt = fill_r - QFILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // queue storage, payload only
  always_ff @(posedge clk) begin
    if (push) begin
      qmem_r[wr_ptr_r] <= push_color;
    end
  end

endmodule

// ===== hw/rtl/pip_palette_search.sv =====
// back end: scans the palette memory one entry a cycle, appends new colors
// depends on pip_pkg
module pip_palette_search #(
  parameter int PALETTE_DEPTH = pip_pkg::DEFAULT_PALETTE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            pix_valid,
  output logic            pix_ready,
  input  pip_pkg::color_t pix_color,
  output logic            res_valid,
  input  logic            res_ready,
  output pip_pkg::res_t   res
);
  import pip_pkg::*;

  localparam int IDX_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int CNT_W = $clog2(PALETTE_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESULT
  } state_t;

  state_t             state_r, state_nxt;
  color_t             color_r, color_nxt;
  logic [CNT_W-1:0]   issue_r, issue_nxt;
  logic               cmp_valid_r, cmp_valid_nxt;
  logic [IDX_W-1:0]   cmp_idx_r, cmp_idx_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  res_t               res_r, res_nxt;
  logic               res_valid_r, res_valid_nxt;

  color_t             mem [PALETTE_DEPTH];
  color_t             rd_data_r;
  logic [IDX_W-1:0]   rd_addr;
  logic               wr_en;

  logic               hit, last, full;

  assign pix_ready = (state_r == S_IDLE);
  assign res_valid = res_valid_r;
  assign res       = res_r;
  assign rd_addr   = issue_r[IDX_W-1:0];

  // compare stage checks the palette entry read in the previous cycle
  assign hit  = cmp_valid_r && (rd_data_r == color_r);
  assign last = cmp_valid_r ? ((CNT_W'(cmp_idx_r) + CNT_W'(1)) == count_r)
                            : (issue_r >= count_r);
  assign full = (count_r == CNT_W'(PALETTE_DEPTH));
  assign wr_en = (state_r == S_SCAN) && !hit && last && !full;

  // next-state and result logic
  always_comb begin
    state_nxt     = state_r;
    color_nxt     = color_r;
    issue_nxt     = issue_r;
    cmp_valid_nxt = 1'b0;
    cmp_idx_nxt   = cmp_idx_r;
    count_nxt     = count_r;
    res_nxt       = res_r;
    res_valid_nxt = res_valid_r;
    unique case (state_r)
      S_IDLE: begin
        if (pix_valid) begin
          color_nxt = pix_color;
          issue_nxt = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (issue_r < count_r) begin
          cmp_valid_nxt = 1'b1;
          cmp_idx_nxt   = issue_r[IDX_W-1:0];
          issue_nxt     = issue_r + CNT_W'(1);
        end
        if (hit) begin
          res_nxt.idx    = IDX_BYTE_W'(cmp_idx_r);
          res_nxt.miss   = 1'b0;
          res_nxt.colors = COUNT_W'(count_r);
          res_valid_nxt  = 1'b1;
          cmp_valid_nxt  = 1'b0;
          state_nxt      = S_RESULT;
        end else if (last) begin
          cmp_valid_nxt = 1'b0;
          res_valid_nxt = 1'b1;
          state_nxt     = S_RESULT;
          if (full) begin
            // palette full and color absent
            res_nxt.idx    = '0;
            res_nxt.miss   = 1'b1;
            res_nxt.colors = COUNT_W'(count_r);
          end else begin
            res_nxt.idx    = IDX_BYTE_W'(count_r[IDX_W-1:0]);
            res_nxt.miss   = 1'b0;
            res_nxt.colors = COUNT_W'(count_r + CNT_W'(1));
            count_nxt      = count_r + CNT_W'(1);
          end
        end
      end
      S_RESULT: begin
        if (res_ready) begin
          res_valid_nxt = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cmp_valid_r <= 1'b0;
      count_r     <= '0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cmp_valid_r <= cmp_valid_nxt;
      count_r     <= count_nxt;
      res_valid_r <= res_valid_nxt;
    end
    color_r   <= color_nxt;
    issue_r   <= issue_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    res_r     <= res_nxt;
  end

  // palette memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[IDX_W-1:0]] <= color_r;
    end
    rd_data_r <= mem[rd_addr];
  end

endmodule

// ===== hw/rtl/pip_word_packer.sv =====
// back end: groups four resolved pixels into one word with a running address
// depends on pip_pkg
module pip_word_packer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        res_valid,
  output logic                        res_ready,
  input  pip_pkg::res_t               res,
  input  logic [pip_pkg::ADDR_W-1:0]  base_address,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [pip_pkg::OUT_DATA_W-1:0] out_tdata
);
  import pip_pkg::*;

  localparam int PART_W  = IDX_BYTE_W * (PIXELS_PER_WORD - 1);
  localparam int PMISS_W = PIXELS_PER_WORD - 1;
  localparam int PAD_W   = OUT_DATA_W - WORD_W - MASK_W - ADDR_W - COUNT_W;

  logic [GROUP_W-1:0]  group_r;
  logic [PART_W-1:0]   part_idx_r;
  logic [PMISS_W-1:0]  part_miss_r;
  logic [ADDR_W-1:0]   offset_r;
  logic                out_valid_r;
  logic [WORD_W-1:0]   word_r;
  logic [MASK_W-1:0]   mask_r;
  logic [ADDR_W-1:0]   addr_r;
  logic [COUNT_W-1:0]  colors_r;
  logic                take, last_pix;

  assign last_pix   = (group_r == GROUP_W'(PIXELS_PER_WORD - 1));
  assign res_ready  = !last_pix || !out_valid_r || out_tready;
  assign take       = res_valid && res_ready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PAD_W{1'b0}}, colors_r, addr_r, mask_r, word_r};

  // group assembly and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_r     <= '0;
      part_idx_r  <= '0;
      part_miss_r <= '0;
      offset_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // a new word fills the output register, otherwise it drains on a transaction
      if (take && last_pix) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (take) begin
        if (!last_pix) begin
          part_idx_r  <= {part_idx_r[PART_W-IDX_BYTE_W-1:0], res.idx};
          part_miss_r <= {part_miss_r[PMISS_W-2:0], res.miss};
          group_r     <= group_r + GROUP_W'(1);
        end else begin
          part_idx_r  <= '0;
          part_miss_r <= '0;
          group_r     <= '0;
          offset_r    <= offset_r + ADDR_W'(1);
        end
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (take && last_pix) begin
      word_r   <= {part_idx_r, res.idx};
      mask_r   <= {part_miss_r, res.miss};
      addr_r   <= base_address + offset_r;
      colors_r <= res.colors;
    end
  end

endmodule

// ===== hw/rtl/palette_index_packer.sv =====
// Palette index packer: maps each RGB pixel to an index in a palette that
// fills in first-come order and emits one 32-bit word for every four pixels.
// The search reads the palette memory through its single read port, one entry
// a cycle. A two-entry input queue and an output register let both sides stall
// freely. A color absent from a full palette gives index 0 and sets its miss
// bit. base_address is written through the cfg channel; the user must do so
// only while the block is idle, the block itself does not enforce it.
// depends on pip_pkg, pip_pixel_queue, pip_palette_search, pip_word_packer
module palette_index_packer #(
  parameter int PALETTE_DEPTH = pip_pkg::DEFAULT_PALETTE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // red [7:0], green [15:8], blue [23:16]
  input  logic [pip_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // packed_word [31:0], miss_mask [35:32], word_address [51:36],
  // colors_used [60:52], zero [63:61]
  output logic [pip_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pip_pkg::ADDR_W-1:0]     cfg_data
);
  import pip_pkg::*;

  color_t             in_color;
  color_t             q_color;
  logic               q_valid, q_ready;
  logic               res_valid, res_ready;
  res_t               res;
  logic [ADDR_W-1:0]  base_r;

  assign in_color  = {in_tdata[7:0], in_tdata[15:8], in_tdata[23:16]};
  assign cfg_ready = 1'b1;

  // base address register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      base_r <= cfg_data;
    end
  end

  pip_pixel_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_tvalid),
    .push_ready (in_tready),
    .push_color (in_color),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_color  (q_color)
  );

  pip_palette_search #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_search (
    .clk       (clk),
    .rst_n     (rst_n),
    .pix_valid (q_valid),
    .pix_ready (q_ready),
    .pix_color (q_color),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  pip_word_packer u_packer (
    .clk          (clk),
    .rst_n        (rst_n),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res),
    .base_address (base_r),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata)
  );

endmodule

// ===== hw/rtl/pip_checker.sv =====
// port-level checks for the palette index packer, bound to the top level
// depends on pip_pkg and palette_index_packer
module pip_checker #(
  parameter int PALETTE_DEPTH = pip_pkg::DEFAULT_PALETTE_DEPTH
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [pip_pkg::OUT_DATA_W-1:0] out_tdata
);
  import pip_pkg::*;

  logic [WORD_W-1:0]  w;
  logic [MASK_W-1:0]  m;
  logic [COUNT_W-1:0] used;

  assign w    = out_tdata[31:0];
  assign m    = out_tdata[35:32];
  assign used = out_tdata[60:52];

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // a miss only happens with a full palette
  a_miss_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (m != '0) |-> used == COUNT_W'(PALETTE_DEPTH))
    else $error("miss reported with palette not full");

  // a missed pixel carries index zero
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (!m[3] || w[31:24] == '0) && (!m[2] || w[23:16] == '0) &&
                   (!m[1] || w[15:8] == '0) && (!m[0] || w[7:0] == '0))
    else $error("missed pixel has nonzero index");

  // palette fill is never zero and never exceeds its depth
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> used <= COUNT_W'(PALETTE_DEPTH) && used != '0)
    else $error("colors used out of range");

endmodule

bind palette_index_packer pip_checker #(
  .PALETTE_DEPTH (PALETTE_DEPTH)
) u_pip_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== bench/palette_index_checker.sv =====
`timescale 1ns / 100ps
// checker for the palette index packer: watches the pixel, word and config channels,
// predicts every packed word and compares it field by field; depends on pip_pkg
module palette_index_checker #(
  parameter int PALETTE_DEPTH = pip_pkg::DEFAULT_PALETTE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [pip_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [pip_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [pip_pkg::ADDR_W-1:0]     cfg_data,
  output int                             fail_count,
  output int                             words_pending,
  output int                             words_checked,
  output int                             missed_pixels
);

  localparam int STORE_LIMIT = (PALETTE_DEPTH > 256) ? 256 : PALETTE_DEPTH;

  typedef struct {
    logic [pip_pkg::WORD_W-1:0]  indexes;
    logic [pip_pkg::MASK_W-1:0]  misses;
    logic [pip_pkg::ADDR_W-1:0]  address;
    logic [pip_pkg::COUNT_W-1:0] colors;
  } packed_result_t;

  // predicted block state
  pip_pkg::color_t             palette_colors [0:255];
  logic [pip_pkg::COUNT_W-1:0] colors_filled;
  logic [1:0]                  pixel_slot;
  logic [23:0]                 index_accum;
  logic [2:0]                  miss_accum;
  logic [pip_pkg::ADDR_W-1:0]  word_count;
  logic [pip_pkg::ADDR_W-1:0]  cur_base;

  packed_result_t expected_words [$];

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t ns: %s: got %0h, want %0h", $time, what, got, want);
    fail_count++;
  endtask

  // predict on each pixel transaction, compare on each word transaction
  always @(posedge clk) begin : predict_and_compare
    pip_pkg::color_t rgb;
    logic [7:0]      idx;
    logic            miss;
    bit              found;
    packed_result_t  want;
    packed_result_t  got;
    if (!rst_n) begin
      colors_filled = '0;
      pixel_slot    = '0;
      index_accum   = '0;
      miss_accum    = '0;
      word_count    = '0;
      cur_base      = '0;
      expected_words.delete();
      fail_count    = 0;
      words_pending = 0;
      words_checked = 0;
      missed_pixels = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cur_base = cfg_data;
      end

      if (in_tvalid && in_tready) begin
        rgb   = {in_tdata[7:0], in_tdata[15:8], in_tdata[23:16]};
        idx   = '0;
        miss  = 1'b0;
        found = 1'b0;
        // first match in insertion order wins
        for (int i = 0; i < STORE_LIMIT; i++) begin
          if (!found && i < colors_filled && palette_colors[i] == rgb) begin
            idx   = i[7:0];
            found = 1'b1;
          end
        end
        if (!found) begin
          if (colors_filled < STORE_LIMIT) begin
            idx = colors_filled[7:0];
            palette_colors[colors_filled[7:0]] = rgb;
            colors_filled++;
          end else begin
            // palette full and color absent
            miss = 1'b1;
            missed_pixels++;
          end
        end
        if (pixel_slot != 2'd3) begin
          index_accum = {index_accum[15:0], idx};
          miss_accum  = {miss_accum[1:0], miss};
          pixel_slot++;
        end else begin
          want.indexes = {index_accum, idx};
          want.misses  = {miss_accum, miss};
          want.address = cur_base + word_count;
          want.colors  = colors_filled;
          expected_words.push_back(want);
          word_count++;
          pixel_slot  = '0;
          index_accum = '0;
          miss_accum  = '0;
        end
      end

      if (out_tvalid && out_tready) begin
        got.indexes = out_tdata[31:0];
        got.misses  = out_tdata[35:32];
        got.address = out_tdata[51:36];
        got.colors  = out_tdata[60:52];
        if (expected_words.size() == 0) begin
          report_mismatch("word with nothing expected", got.indexes, 0);
        end else begin
          want = expected_words.pop_front();
          if (got.indexes !== want.indexes)
            report_mismatch("packed_word", got.indexes, want.indexes);
          if (got.misses !== want.misses)
            report_mismatch("miss_mask", got.misses, want.misses);
          if (got.address !== want.address)
            report_mismatch("word_address", got.address, want.address);
          if (got.colors !== want.colors)
            report_mismatch("colors_used", got.colors, want.colors);
          words_checked++;
        end
      end

      words_pending = expected_words.size();
    end
  end

endmodule

// ===== bench/palette_index_packer_test.sv =====
`timescale 1ns / 100ps
// top of the palette index packer bench: clock, reset, pixel and config stimulus,
// random stalls on the word channel and the verdict; depends on pip_pkg, the packer and the checker
module palette_index_packer_test;

  localparam int PALETTE_DEPTH  = pip_pkg::DEFAULT_PALETTE_DEPTH;
  // twice the longest pixel search plus margin, used to let the block go quiet
  localparam int SETTLE_CYCLES  = 2 * (PALETTE_DEPTH + 3) + 20;
  localparam int WATCHDOG_LIMIT = 4 * SETTLE_CYCLES + 1000;
  localparam int RANDOM_PHASES  = 5;
  localparam int PHASE_PIXELS   = 346;

  logic                           clk        = 1'b0;
  logic                           rst_n      = 1'b0;
  logic                           in_tvalid  = 1'b0;
  logic                           in_tready;
  logic [pip_pkg::IN_DATA_W-1:0]  in_tdata   = '0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [pip_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                           cfg_valid  = 1'b0;
  logic                           cfg_ready;
  logic [pip_pkg::ADDR_W-1:0]     cfg_data   = '0;

  int fail_count;
  int words_pending;
  int words_checked;
  int missed_pixels;

  bit              idle_on = 1'b1;
  int              pixels_sent;
  int              cfg_writes;
  int              quiet_cycles;
  pip_pkg::color_t sent_colors [$];

  palette_index_packer #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  palette_index_checker #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) word_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .words_pending(words_pending),
    .words_checked(words_checked),
    .missed_pixels(missed_pixels)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // word channel ready in random bursts of ready and stall, always ready once idle_on is cleared
  always begin
    @(negedge clk);
    if (idle_on && $urandom_range(0, 2) == 0) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
    repeat ($urandom_range(1, 16) - 1) @(negedge clk);
  end

  // end the run if no transaction happens for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("simulation failed");
      $finish;
    end
  end

  // one pixel transaction, with an optional gap before it; called at a falling edge
  task automatic send_pixel(input pip_pkg::color_t rgb);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_tdata  <= {rgb[7:0], rgb[15:8], rgb[23:16]};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    sent_colors.push_back(rgb);
    pixels_sent++;
  endtask

  // one base address write transaction
  task automatic write_base(input logic [pip_pkg::ADDR_W-1:0] value);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  // stop sending, wait for every predicted word, then let a partial group finish its search
  task automatic settle();
    in_tvalid <= 1'b0;
    while (words_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin : stimulus
    pip_pkg::color_t rgb;
    logic [31:0]     word;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // directed: channel extremes, duplicates, base address near the wrap
    write_base(16'hFFFE);
    for (int k = 0; k < 24; k++) begin
      case (k)
        0:       rgb = 24'h000000;
        1:       rgb = 24'hFFFFFF;
        2:       rgb = 24'hFF0000;
        3:       rgb = 24'h00FF00;
        4:       rgb = 24'h0000FF;
        5:       rgb = 24'h000000;
        6:       rgb = 24'hFFFFFF;
        7:       rgb = 24'h808080;
        8:       rgb = 24'h7F7F7F;
        9:       rgb = 24'hAAAAAA;
        10:      rgb = 24'h555555;
        11:      rgb = 24'h000001;
        12:      rgb = 24'h800000;
        13:      rgb = 24'h008000;
        14:      rgb = 24'h000080;
        15:      rgb = 24'hFF00FF;
        16:      rgb = 24'h00FFFF;
        17:      rgb = 24'hFFFF00;
        18:      rgb = 24'h123456;
        19:      rgb = 24'hFEDCBA;
        20:      rgb = 24'h0000FF;
        21:      rgb = 24'h123456;
        22:      rgb = 24'h000000;
        default: rgb = 24'hFFFFFF;
      endcase
      send_pixel(rgb);
    end
    settle();

    // random phases: reused colors, channel extremes and fresh colors that fill the palette
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0:       write_base(16'h0000);
        1:       write_base(16'hFFFF);
        3:       write_base(16'h8000);
        default: begin
          word = $urandom;
          write_base(word[15:0]);
        end
      endcase
      // last phase runs with both sides at full rate
      if (phase == RANDOM_PHASES - 1) idle_on = 1'b0;
      for (int n = 0; n < PHASE_PIXELS; n++) begin
        word = $urandom;
        case ($urandom_range(0, 7))
          0, 1, 2: rgb = sent_colors[$urandom_range(0, sent_colors.size() - 1)];
          3:       rgb = {word[0] ? 8'hFF : 8'h00, word[1] ? 8'hFF : 8'h00,
                          word[2] ? 8'hFF : 8'h00};
          default: rgb = word[23:0];
        endcase
        send_pixel(rgb);
      end
      settle();
    end

    $display("sent %0d pixels under %0d base address settings, checked %0d packed words",
             pixels_sent, cfg_writes, words_checked);
    $display("%0d pixels arrived with the palette full and their color absent",
             missed_pixels);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== palette_index_packer.f =====
hw/rtl/pip_pkg.sv
hw/rtl/pip_pixel_queue.sv
hw/rtl/pip_palette_search.sv
hw/rtl/pip_word_packer.sv
hw/rtl/palette_index_packer.sv
hw/rtl/pip_checker.sv
bench/palette_index_checker.sv
bench/palette_index_packer_test.sv
